@@ hdl/bankers_request_safety_check_top_assert.svh @@
// assertion macros for the banker's request checker
`ifndef BANKERS_REQUEST_SAFETY_CHECK_TOP_ASSERT_SVH
`define BANKERS_REQUEST_SAFETY_CHECK_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BRSC_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BRSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/brsc_pkg.sv @@
package brsc_pkg;

    localparam int MAX_PROCS_DEF  = 8;
    localparam int MAX_RES_DEF    = 4;
    localparam int COUNT_BITS_DEF = 8;

    localparam int ACT_W    = 2;
    localparam int STATUS_W = 3;
    localparam int ID_W     = 8;
    localparam int VAL_W    = 8;
    localparam int CFG_W    = 3;

    localparam logic [CFG_W-1:0] ACTIVE_RES_RESET = 3'd4;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_SET     = 2'd1,
        ACT_REQUEST = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED       = 3'd0,
        ST_UNKNOWN       = 3'd1,
        ST_EXCEEDS_NEED  = 3'd2,
        ST_EXCEEDS_AVAIL = 3'd3,
        ST_UNSAFE        = 3'd4,
        ST_ACCEPTED      = 3'd5,
        ST_LOAD_REJECTED = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SET,
        S_LOOKUP,
        S_CHECK,
        S_GRANT,
        S_SCAN_INIT,
        S_SCAN,
        S_EMIT,
        S_ROLLBACK
    } state_t;

endpackage

@@ hdl/bankers_request_safety_check_top.sv @@
// Banker's algorithm request checker. An item is taken when start is high and busy is
// low; busy stays high until the item is finished. Results come out one per cycle on
// status, seq_process_id and last, marked by result_valid for a single cycle, and must
// be taken as they come since the receiver cannot stall the block. A load or set is
// answered from its S_LOAD or S_SET state through the registered result. A request
// steps through the table one row a cycle to find the process, one resource a cycle
// to check need and available, then runs the safety scan one row a cycle for up to
// MAX_PROCS passes over the table, and on a grant sends the safe sequence one
// identifier a cycle. The configuration port is ready whenever the block is not busy.
`include "bankers_request_safety_check_top_assert.svh"

module bankers_request_safety_check_top #(
    parameter int MAX_PROCS  = brsc_pkg::MAX_PROCS_DEF,
    parameter int MAX_RES    = brsc_pkg::MAX_RES_DEF,
    parameter int COUNT_BITS = brsc_pkg::COUNT_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [brsc_pkg::ACT_W-1:0]     action,
    input  logic [brsc_pkg::ID_W-1:0]      process_id,
    input  logic [brsc_pkg::VAL_W-1:0]     value_a_0,
    input  logic [brsc_pkg::VAL_W-1:0]     value_a_1,
    input  logic [brsc_pkg::VAL_W-1:0]     value_a_2,
    input  logic [brsc_pkg::VAL_W-1:0]     value_a_3,
    input  logic [brsc_pkg::VAL_W-1:0]     value_b_0,
    input  logic [brsc_pkg::VAL_W-1:0]     value_b_1,
    input  logic [brsc_pkg::VAL_W-1:0]     value_b_2,
    input  logic [brsc_pkg::VAL_W-1:0]     value_b_3,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [brsc_pkg::CFG_W-1:0]     cfg_data,
    output logic                           result_valid,
    output logic [brsc_pkg::STATUS_W-1:0]  status,
    output logic [brsc_pkg::ID_W-1:0]      seq_process_id,
    output logic                           last
);

    localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int RIDX_W = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
    localparam int RES_W  = $clog2(MAX_RES + 1);
    localparam int WORK_W = COUNT_BITS + CNT_W;

    localparam logic [CNT_W-1:0]           PROCS_C = CNT_W'(MAX_PROCS);
    localparam logic [brsc_pkg::CFG_W-1:0] RES_C   = brsc_pkg::CFG_W'(MAX_RES);

    typedef logic [COUNT_BITS-1:0] units_t;
    typedef logic [WORK_W-1:0]     work_t;

    logic [brsc_pkg::VAL_W-1:0] a_port [4];
    logic [brsc_pkg::VAL_W-1:0] b_port [4];
    units_t                     a_in   [MAX_RES];
    units_t                     b_in   [MAX_RES];

    brsc_pkg::state_t           state_reg, state_next;
    logic [brsc_pkg::CFG_W-1:0] active_res_reg;
    logic [CNT_W-1:0]           count_reg;

    logic [brsc_pkg::ID_W-1:0]  id_reg    [MAX_PROCS];
    units_t                     max_reg   [MAX_PROCS][MAX_RES];
    units_t                     alloc_reg [MAX_PROCS][MAX_RES];
    units_t                     avail_reg [MAX_RES];
    work_t                      work_reg  [MAX_RES];
    logic [MAX_PROCS-1:0]       done_reg;
    logic [IDX_W-1:0]           seq_reg   [MAX_PROCS];

    logic [brsc_pkg::ID_W-1:0]  pid_reg;
    units_t                     a_reg [MAX_RES];
    units_t                     b_reg [MAX_RES];

    logic [IDX_W-1:0]           row_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [IDX_W-1:0]           emit_reg;
    logic [RES_W-1:0]           res_reg;
    logic [CNT_W-1:0]           found_cnt_reg;
    logic                       found_reg;

    logic                       valid_reg;
    brsc_pkg::status_t          status_reg;
    logic [brsc_pkg::ID_W-1:0]  seq_id_reg;
    logic                       last_reg;

    logic [RES_W-1:0]           nres;
    logic [MAX_RES-1:0]         res_en;
    logic [MAX_RES-1:0]         load_over;
    logic [MAX_RES-1:0]         fits_s;
    logic                       load_bad;
    logic                       hit;
    logic                       row_last;
    logic [RIDX_W-1:0]          ridx;
    units_t                     need_c;
    logic                       over_need;
    logic                       over_avail;
    logic                       res_last;
    logic                       row_ok;
    logic [CNT_W-1:0]           cnt_after;
    logic                       found_after;
    logic                       emit_last;
    logic [brsc_pkg::ID_W-1:0]  emit_id;

    logic                       take_item;
    logic                       load_wr;
    logic                       set_wr;
    logic                       idx_load;
    logic                       row_inc;
    logic                       res_inc;
    logic                       grant_wr;
    logic                       rollback_wr;
    logic                       scan_init;
    logic                       scan_step;
    logic                       emit_inc;
    logic                       res_fire;
    brsc_pkg::status_t          res_status;
    logic [brsc_pkg::ID_W-1:0]  res_id;
    logic                       res_last_flag;

    assign a_port[0] = value_a_0;
    assign a_port[1] = value_a_1;
    assign a_port[2] = value_a_2;
    assign a_port[3] = value_a_3;
    assign b_port[0] = value_b_0;
    assign b_port[1] = value_b_1;
    assign b_port[2] = value_b_2;
    assign b_port[3] = value_b_3;

    // per resource: input truncation, enables, load check, scan fit
    for (genvar g = 0; g < MAX_RES; g++)
    begin : g_res
        logic [COUNT_BITS+brsc_pkg::VAL_W-1:0] a_ext;
        logic [COUNT_BITS+brsc_pkg::VAL_W-1:0] b_ext;
        units_t                                need_s;

        assign a_ext        = {{COUNT_BITS{1'b0}}, a_port[g]};
        assign b_ext        = {{COUNT_BITS{1'b0}}, b_port[g]};
        assign a_in[g]      = a_ext[COUNT_BITS-1:0];
        assign b_in[g]      = b_ext[COUNT_BITS-1:0];
        assign res_en[g]    = RES_W'(g) < nres;
        assign load_over[g] = b_reg[g] > a_reg[g];
        assign need_s       = max_reg[row_reg][g] - alloc_reg[row_reg][g];
        assign fits_s[g]    = !res_en[g] || (WORK_W'(need_s) <= work_reg[g]);
    end

    always_comb
    begin
        if (active_res_reg == '0)
        begin
            nres = RES_W'(1);
        end
        else if (active_res_reg > RES_C)
        begin
            nres = RES_W'(RES_C);
        end
        else
        begin
            nres = RES_W'(active_res_reg);
        end
    end

    assign load_bad    = (count_reg == PROCS_C) || (|load_over);
    assign hit         = id_reg[row_reg] == pid_reg;
    assign row_last    = (CNT_W'(row_reg) + CNT_W'(1)) == count_reg;
    assign ridx        = res_reg[RIDX_W-1:0];
    assign need_c      = max_reg[idx_reg][ridx] - alloc_reg[idx_reg][ridx];
    assign over_need   = a_reg[ridx] > need_c;
    assign over_avail  = a_reg[ridx] > avail_reg[ridx];
    assign res_last    = (res_reg + RES_W'(1)) == nres;
    assign row_ok      = !done_reg[row_reg] && (&fits_s);
    assign cnt_after   = found_cnt_reg + CNT_W'(row_ok);
    assign found_after = found_reg | row_ok;
    assign emit_last   = (CNT_W'(emit_reg) + CNT_W'(1)) == count_reg;
    assign emit_id     = id_reg[seq_reg[emit_reg]];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brsc_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        brsc_pkg::ACT_LOAD:    state_next = brsc_pkg::S_LOAD;
                        brsc_pkg::ACT_SET:     state_next = brsc_pkg::S_SET;
                        brsc_pkg::ACT_REQUEST: state_next = brsc_pkg::S_LOOKUP;
                        default:               state_next = brsc_pkg::S_IDLE;
                    endcase
                end
            end
            brsc_pkg::S_LOAD:      state_next = brsc_pkg::S_IDLE;
            brsc_pkg::S_SET:       state_next = brsc_pkg::S_IDLE;
            brsc_pkg::S_LOOKUP:
            begin
                if (count_reg == '0)
                begin
                    state_next = brsc_pkg::S_IDLE;
                end
                else if (hit)
                begin
                    state_next = brsc_pkg::S_CHECK;
                end
                else if (row_last)
                begin
                    state_next = brsc_pkg::S_IDLE;
                end
            end
            brsc_pkg::S_CHECK:
            begin
                if (over_need || over_avail)
                begin
                    state_next = brsc_pkg::S_IDLE;
                end
                else if (res_last)
                begin
                    state_next = brsc_pkg::S_GRANT;
                end
            end
            brsc_pkg::S_GRANT:     state_next = brsc_pkg::S_SCAN_INIT;
            brsc_pkg::S_SCAN_INIT: state_next = brsc_pkg::S_SCAN;
            brsc_pkg::S_SCAN:
            begin
                if (row_last)
                begin
                    if (cnt_after == count_reg)
                    begin
                        state_next = brsc_pkg::S_EMIT;
                    end
                    else if (!found_after)
                    begin
                        state_next = brsc_pkg::S_ROLLBACK;
                    end
                end
            end
            brsc_pkg::S_EMIT:
            begin
                if (emit_last)
                begin
                    state_next = brsc_pkg::S_IDLE;
                end
            end
            brsc_pkg::S_ROLLBACK:  state_next = brsc_pkg::S_IDLE;
            default:               state_next = brsc_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        take_item     = 1'b0;
        load_wr       = 1'b0;
        set_wr        = 1'b0;
        idx_load      = 1'b0;
        row_inc       = 1'b0;
        res_inc       = 1'b0;
        grant_wr      = 1'b0;
        rollback_wr   = 1'b0;
        scan_init     = 1'b0;
        scan_step     = 1'b0;
        emit_inc      = 1'b0;
        res_fire      = 1'b0;
        res_status    = brsc_pkg::ST_ACCEPTED;
        res_id        = '0;
        res_last_flag = 1'b1;
        case (state_reg)
            brsc_pkg::S_IDLE:
            begin
                take_item = start;
            end
            brsc_pkg::S_LOAD:
            begin
                load_wr    = !load_bad;
                res_fire   = 1'b1;
                res_status = load_bad ? brsc_pkg::ST_LOAD_REJECTED : brsc_pkg::ST_ACCEPTED;
            end
            brsc_pkg::S_SET:
            begin
                set_wr   = 1'b1;
                res_fire = 1'b1;
            end
            brsc_pkg::S_LOOKUP:
            begin
                if (count_reg == '0)
                begin
                    res_fire   = 1'b1;
                    res_status = brsc_pkg::ST_UNKNOWN;
                end
                else if (hit)
                begin
                    idx_load = 1'b1;
                end
                else if (row_last)
                begin
                    res_fire   = 1'b1;
                    res_status = brsc_pkg::ST_UNKNOWN;
                end
                else
                begin
                    row_inc = 1'b1;
                end
            end
            brsc_pkg::S_CHECK:
            begin
                if (over_need)
                begin
                    res_fire   = 1'b1;
                    res_status = brsc_pkg::ST_EXCEEDS_NEED;
                end
                else if (over_avail)
                begin
                    res_fire   = 1'b1;
                    res_status = brsc_pkg::ST_EXCEEDS_AVAIL;
                end
                else
                begin
                    res_inc = !res_last;
                end
            end
            brsc_pkg::S_GRANT:
            begin
                grant_wr = 1'b1;
            end
            brsc_pkg::S_SCAN_INIT:
            begin
                scan_init = 1'b1;
            end
            brsc_pkg::S_SCAN:
            begin
                scan_step = 1'b1;
            end
            brsc_pkg::S_EMIT:
            begin
                emit_inc      = 1'b1;
                res_fire      = 1'b1;
                res_status    = brsc_pkg::ST_GRANTED;
                res_id        = emit_id;
                res_last_flag = emit_last;
            end
            brsc_pkg::S_ROLLBACK:
            begin
                rollback_wr = 1'b1;
                res_fire    = 1'b1;
                res_status  = brsc_pkg::ST_UNSAFE;
            end
            default:
            begin
                take_item = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= brsc_pkg::S_IDLE;
            active_res_reg <= brsc_pkg::ACTIVE_RES_RESET;
            count_reg      <= '0;
            valid_reg      <= 1'b0;
            row_reg        <= '0;
            idx_reg        <= '0;
            emit_reg       <= '0;
            res_reg        <= '0;
            found_cnt_reg  <= '0;
            found_reg      <= 1'b0;
            for (int j = 0; j < MAX_RES; j++)
            begin
                avail_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= res_fire;
            if (cfg_valid && cfg_ready)
            begin
                active_res_reg <= cfg_data;
            end
            if (load_wr)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (take_item || scan_init)
            begin
                row_reg <= '0;
            end
            else if (row_inc)
            begin
                row_reg <= row_reg + IDX_W'(1);
            end
            else if (scan_step)
            begin
                row_reg <= row_last ? '0 : row_reg + IDX_W'(1);
            end
            if (idx_load)
            begin
                idx_reg <= row_reg;
                res_reg <= '0;
            end
            else if (res_inc)
            begin
                res_reg <= res_reg + RES_W'(1);
            end
            if (scan_init)
            begin
                emit_reg      <= '0;
                found_cnt_reg <= '0;
                found_reg     <= 1'b0;
            end
            else if (scan_step)
            begin
                found_cnt_reg <= cnt_after;
                found_reg     <= row_last ? 1'b0 : found_after;
            end
            else if (emit_inc)
            begin
                emit_reg <= emit_reg + IDX_W'(1);
            end
            for (int j = 0; j < MAX_RES; j++)
            begin
                if (set_wr)
                begin
                    avail_reg[j] <= a_reg[j];
                end
                else if (grant_wr && res_en[j])
                begin
                    avail_reg[j] <= avail_reg[j] - a_reg[j];
                end
                else if (rollback_wr && res_en[j])
                begin
                    avail_reg[j] <= avail_reg[j] + a_reg[j];
                end
            end
        end
    end

    // tables, scan data and result payload
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            pid_reg <= process_id;
            for (int j = 0; j < MAX_RES; j++)
            begin
                a_reg[j] <= a_in[j];
                b_reg[j] <= b_in[j];
            end
        end
        if (load_wr)
        begin
            id_reg[count_reg[IDX_W-1:0]] <= pid_reg;
            for (int j = 0; j < MAX_RES; j++)
            begin
                max_reg[count_reg[IDX_W-1:0]][j]   <= a_reg[j];
                alloc_reg[count_reg[IDX_W-1:0]][j] <= b_reg[j];
            end
        end
        for (int j = 0; j < MAX_RES; j++)
        begin
            if (grant_wr && res_en[j])
            begin
                alloc_reg[idx_reg][j] <= alloc_reg[idx_reg][j] + a_reg[j];
            end
            else if (rollback_wr && res_en[j])
            begin
                alloc_reg[idx_reg][j] <= alloc_reg[idx_reg][j] - a_reg[j];
            end
        end
        if (scan_init)
        begin
            done_reg <= '0;
            for (int j = 0; j < MAX_RES; j++)
            begin
                work_reg[j] <= WORK_W'(avail_reg[j]);
            end
        end
        else if (scan_step && row_ok)
        begin
            done_reg[row_reg]                      <= 1'b1;
            seq_reg[found_cnt_reg[IDX_W-1:0]]      <= row_reg;
            for (int j = 0; j < MAX_RES; j++)
            begin
                if (res_en[j])
                begin
                    work_reg[j] <= work_reg[j] + WORK_W'(alloc_reg[row_reg][j]);
                end
            end
        end
        if (res_fire)
        begin
            status_reg <= res_status;
            seq_id_reg <= res_id;
            last_reg   <= res_last_flag;
        end
    end

    assign busy           = state_reg != brsc_pkg::S_IDLE;
    assign cfg_ready      = state_reg == brsc_pkg::S_IDLE;
    assign result_valid   = valid_reg;
    assign status         = status_reg;
    assign seq_process_id = seq_id_reg;
    assign last           = last_reg;

    `BRSC_ASSERT(a_last_idle, result_valid && last, !busy, "final item shown while busy")
    `BRSC_ASSERT(a_count_bound, 1'b1, count_reg <= PROCS_C, "process count above table size")
    `BRSC_ASSERT_NEXT(a_ignored_action, start && !busy && action != brsc_pkg::ACT_LOAD && action != brsc_pkg::ACT_SET && action != brsc_pkg::ACT_REQUEST, !busy && !result_valid, "ignored item caused work")
    `BRSC_ASSERT(a_scan_bound, state_reg == brsc_pkg::S_SCAN, found_cnt_reg <= count_reg, "scan found more rows than loaded")
    `BRSC_ASSERT(a_seq_status, result_valid && !last, status == brsc_pkg::ST_GRANTED, "non-final item outside a grant")

endmodule

@@ tb/tb_bankers_request_safety_check_top.sv @@
module tb_bankers_request_safety_check_top;
    import brsc_pkg::*;

    localparam int NPROC = MAX_PROCS_DEF;
    localparam int NRES = MAX_RES_DEF;
    localparam int VEC_W = NRES * VAL_W;
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 100;
    localparam int NUM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 45;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [ACT_W-1:0]           act;
        logic [ID_W-1:0]            pid;
        logic [NRES-1:0][VAL_W-1:0] a;
        logic [NRES-1:0][VAL_W-1:0] b;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [ID_W-1:0]     seq;
        logic                last;
    } result_t;

    typedef struct packed {
        item_t   item;
        logic    typed;
        result_t want;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [ACT_W-1:0]    action = '0;
    logic [ID_W-1:0]     process_id = '0;
    logic [VAL_W-1:0]    value_a_0 = '0;
    logic [VAL_W-1:0]    value_a_1 = '0;
    logic [VAL_W-1:0]    value_a_2 = '0;
    logic [VAL_W-1:0]    value_a_3 = '0;
    logic [VAL_W-1:0]    value_b_0 = '0;
    logic [VAL_W-1:0]    value_b_1 = '0;
    logic [VAL_W-1:0]    value_b_2 = '0;
    logic [VAL_W-1:0]    value_b_3 = '0;
    logic                cfg_valid = 1'b0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                busy;
    logic                cfg_ready;
    logic                result_valid;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     seq_process_id;
    logic                last;

    // predictor copy of the process table
    logic [ID_W-1:0]  pid_rows [NPROC];
    logic [VAL_W-1:0] max_rows [NPROC][NRES];
    logic [VAL_W-1:0] held_rows [NPROC][NRES];
    logic [VAL_W-1:0] free_units [NRES];
    int unsigned      rows_loaded;
    logic [CFG_W-1:0] res_setting;
    int unsigned      safe_order [NPROC];

    result_t          expected_results [$];
    result_t          oldest;
    dir_row_t         dir_rows [$];
    int               errors = 0;
    int               idle_pct = 0;
    logic [CFG_W-1:0] phase_settings [NUM_PHASES] =
        '{3'd1, 3'd7, 3'd2, 3'd0, 3'd3, 3'd5, 3'd6, 3'd4};

    bankers_request_safety_check_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .process_id     (process_id),
        .value_a_0      (value_a_0),
        .value_a_1      (value_a_1),
        .value_a_2      (value_a_2),
        .value_a_3      (value_a_3),
        .value_b_0      (value_b_0),
        .value_b_1      (value_b_1),
        .value_b_2      (value_b_2),
        .value_b_3      (value_b_3),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .status         (status),
        .seq_process_id (seq_process_id),
        .last           (last)
    );

    always #6 clk = ~clk;

    function automatic int unsigned res_span();
        if (res_setting == 0)
            return 1;
        if (res_setting > NRES)
            return NRES;
        return 32'(res_setting);
    endfunction

    function automatic result_t status_only(logic [STATUS_W-1:0] st);
        result_t r;
        r.st = st;
        r.seq = '0;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic bit scan_is_safe(int unsigned nres);
        int unsigned work [NRES];
        bit          finished [NPROC];
        int unsigned cnt;
        int unsigned need;
        bit          found;
        bit          fits;
        for (int j = 0; j < NRES; j++)
            work[j] = 32'(free_units[j]);
        for (int i = 0; i < NPROC; i++)
            finished[i] = 1'b0;
        cnt = 0;
        while (cnt < rows_loaded)
        begin
            found = 1'b0;
            for (int i = 0; i < rows_loaded; i++)
            begin
                if (!finished[i])
                begin
                    fits = 1'b1;
                    for (int j = 0; j < nres; j++)
                    begin
                        need = 32'(max_rows[i][j]) - 32'(held_rows[i][j]);
                        if (need > work[j])
                            fits = 1'b0;
                    end
                    if (fits)
                    begin
                        for (int j = 0; j < nres; j++)
                            work[j] += 32'(held_rows[i][j]);
                        safe_order[cnt] = i;
                        cnt++;
                        finished[i] = 1'b1;
                        found = 1'b1;
                    end
                end
            end
            if (!found)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_item(item_t it, bit keep);
        result_t             out [$];
        result_t             r;
        int unsigned         nres;
        int unsigned         hit_row;
        int unsigned         need;
        bit                  hit;
        bit                  over;
        logic [STATUS_W-1:0] fail_st;
        nres = res_span();
        hit_row = 0;
        case (it.act)
            ACT_LOAD:
            begin
                over = 1'b0;
                for (int j = 0; j < NRES; j++)
                    if (it.b[j] > it.a[j])
                        over = 1'b1;
                if (rows_loaded >= NPROC || over)
                    out.insert(out.size(), status_only(ST_LOAD_REJECTED));
                else
                begin
                    pid_rows[rows_loaded] = it.pid;
                    for (int j = 0; j < NRES; j++)
                    begin
                        max_rows[rows_loaded][j] = it.a[j];
                        held_rows[rows_loaded][j] = it.b[j];
                    end
                    rows_loaded++;
                    out.insert(out.size(), status_only(ST_ACCEPTED));
                end
            end
            ACT_SET:
            begin
                for (int j = 0; j < NRES; j++)
                    free_units[j] = it.a[j];
                out.insert(out.size(), status_only(ST_ACCEPTED));
            end
            ACT_REQUEST:
            begin
                hit = 1'b0;
                for (int i = 0; i < rows_loaded; i++)
                begin
                    if (!hit && pid_rows[i] == it.pid)
                    begin
                        hit = 1'b1;
                        hit_row = i;
                    end
                end
                if (!hit)
                    out.insert(out.size(), status_only(ST_UNKNOWN));
                else
                begin
                    fail_st = ST_GRANTED;
                    for (int j = 0; j < nres; j++)
                    begin
                        if (fail_st == ST_GRANTED)
                        begin
                            need = 32'(max_rows[hit_row][j]) - 32'(held_rows[hit_row][j]);
                            if (it.a[j] > need)
                                fail_st = ST_EXCEEDS_NEED;
                            else if (it.a[j] > free_units[j])
                                fail_st = ST_EXCEEDS_AVAIL;
                        end
                    end
                    if (fail_st != ST_GRANTED)
                        out.insert(out.size(), status_only(fail_st));
                    else
                    begin
                        for (int j = 0; j < nres; j++)
                        begin
                            free_units[j] -= it.a[j];
                            held_rows[hit_row][j] += it.a[j];
                        end
                        if (!scan_is_safe(nres))
                        begin
                            for (int j = 0; j < nres; j++)
                            begin
                                free_units[j] += it.a[j];
                                held_rows[hit_row][j] -= it.a[j];
                            end
                            out.insert(out.size(), status_only(ST_UNSAFE));
                        end
                        else
                        begin
                            for (int i = 0; i < rows_loaded; i++)
                            begin
                                r.st = ST_GRANTED;
                                r.seq = pid_rows[safe_order[i]];
                                r.last = (i + 1 == rows_loaded);
                                out.insert(out.size(), r);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        if (keep)
            foreach (out[k])
                expected_results.insert(expected_results.size(), out[k]);
    endfunction

    function automatic dir_row_t dir_entry(logic [ACT_W-1:0] act, logic [ID_W-1:0] pid,
                                           logic [VEC_W-1:0] a, logic [VEC_W-1:0] b,
                                           logic typed, logic [STATUS_W-1:0] st,
                                           logic [ID_W-1:0] seq);
        dir_row_t d;
        d.item.act = act;
        d.item.pid = pid;
        d.item.a = a;
        d.item.b = b;
        d.typed = typed;
        d.want.st = st;
        d.want.seq = seq;
        d.want.last = 1'b1;
        return d;
    endfunction

    function automatic void add_row(dir_row_t d);
        dir_rows.insert(dir_rows.size(), d);
    endfunction

    function automatic item_t random_item();
        item_t       it;
        int unsigned pick;
        int unsigned row;
        it.act = ACT_REQUEST;
        it.pid = ID_W'($urandom);
        it.a = VEC_W'($urandom);
        it.b = VEC_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 58 && rows_loaded > 0)
        begin
            // request for a loaded process with plausible amounts
            row = $urandom_range(rows_loaded - 1);
            it.pid = pid_rows[row];
            for (int j = 0; j < NRES; j++)
            begin
                if ($urandom_range(7) == 0)
                    it.a[j] = max_rows[row][j] - held_rows[row][j];
                else if ($urandom_range(3) == 0)
                    it.a[j] = '0;
                else
                    it.a[j] = VAL_W'($urandom_range(12));
            end
        end
        else if (pick < 65)
            it.act = ACT_REQUEST;
        else if (pick < 82)
        begin
            it.act = ACT_SET;
            if ($urandom_range(1) == 1)
                for (int j = 0; j < NRES; j++)
                    it.a[j] = VAL_W'($urandom_range(255, 120));
        end
        else if (pick < 94)
            it.act = ACT_LOAD;
        else
            it.act = ACT_NONE;
        return it;
    endfunction

    task automatic issue(item_t it, bit typed, result_t want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (idle_pct > 0 && $urandom_range(19) == 0)
            gap += $urandom_range(90);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action <= it.act;
        process_id <= it.pid;
        value_a_0 <= it.a[0];
        value_a_1 <= it.a[1];
        value_a_2 <= it.a[2];
        value_a_3 <= it.a[3];
        value_b_0 <= it.b[0];
        value_b_1 <= it.b[1];
        value_b_2 <= it.b[2];
        value_b_3 <= it.b[3];
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        predict_item(it, !typed);
        if (typed)
            expected_results.insert(expected_results.size(), want);
    endtask

    task automatic write_res_setting(logic [CFG_W-1:0] v);
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        res_setting = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: status %0d seq %02h last %b",
                             status, seq_process_id, last);
            end
            else
            begin
                oldest = expected_results.pop_front();
                if (status !== oldest.st || seq_process_id !== oldest.seq ||
                    last !== oldest.last)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch: status %0d/%0d seq %02h/%02h last %b/%b (exp/got)",
                                 oldest.st, status, oldest.seq, seq_process_id,
                                 oldest.last, last);
                end
            end
        end
    end

    initial
    begin
        item_t it;
        int    counted;
        rows_loaded = 0;
        res_setting = ACTIVE_RES_RESET;
        for (int j = 0; j < NRES; j++)
            free_units[j] = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // action, process, amounts a, amounts b, typed, status, sequence id
        add_row(dir_entry(ACT_REQUEST, 8'h00, 32'h0, 32'h0, 1'b1, ST_UNKNOWN, 8'h00));
        add_row(dir_entry(ACT_NONE, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                          1'b0, ST_GRANTED, 8'h00));
        add_row(dir_entry(ACT_LOAD, 8'hFF, 32'hFFFFFFFF, 32'h0,
                          1'b1, ST_ACCEPTED, 8'h00));
        add_row(dir_entry(ACT_LOAD, 8'h11, 32'h0A0A0A0A, 32'h0000000B,
                          1'b1, ST_LOAD_REJECTED, 8'h00));
        add_row(dir_entry(ACT_LOAD, 8'h12, 32'h0A0A0A0A, 32'h0B000000,
                          1'b1, ST_LOAD_REJECTED, 8'h00));
        add_row(dir_entry(ACT_REQUEST, 8'hFF, 32'h00000001, 32'h0,
                          1'b1, ST_EXCEEDS_AVAIL, 8'h00));
        add_row(dir_entry(ACT_REQUEST, 8'hFF, 32'h0, 32'h0, 1'b1, ST_UNSAFE, 8'h00));
        add_row(dir_entry(ACT_SET, 8'h00, 32'hFFFFFFFF, 32'h0,
                          1'b1, ST_ACCEPTED, 8'h00));
        add_row(dir_entry(ACT_REQUEST, 8'hFF, 32'h0, 32'h0, 1'b1, ST_GRANTED, 8'hFF));
        add_row(dir_entry(ACT_REQUEST, 8'hFF, 32'h00000101, 32'h0,
                          1'b0, ST_GRANTED, 8'h00));
        add_row(dir_entry(ACT_LOAD, 8'h00, 32'h80808080, 32'h10101010,
                          1'b1, ST_ACCEPTED, 8'h00));
        add_row(dir_entry(ACT_LOAD, 8'h5A, 32'hC8C8C8C8, 32'h01020304,
                          1'b1, ST_ACCEPTED, 8'h00));
        add_row(dir_entry(ACT_LOAD, 8'hA5, 32'hF0E0D0C0, 32'h0,
                          1'b1, ST_ACCEPTED, 8'h00));
        // duplicate identifier, never matched by a request
        add_row(dir_entry(ACT_LOAD, 8'h00, 32'h20202020, 32'h20202020,
                          1'b1, ST_ACCEPTED, 8'h00));
        add_row(dir_entry(ACT_LOAD, 8'h3C, 32'h64646464, 32'h05050505,
                          1'b1, ST_ACCEPTED, 8'h00));
        add_row(dir_entry(ACT_LOAD, 8'h81, 32'hFAFAFAFA, 32'h0A0A0A0A,
                          1'b1, ST_ACCEPTED, 8'h00));
        add_row(dir_entry(ACT_LOAD, 8'h7E, 32'hE6E6E6E6, 32'h07070707,
                          1'b1, ST_ACCEPTED, 8'h00));
        // table full
        add_row(dir_entry(ACT_LOAD, 8'h42, 32'h01010101, 32'h0,
                          1'b1, ST_LOAD_REJECTED, 8'h00));
        add_row(dir_entry(ACT_REQUEST, 8'h00, 32'h00000071, 32'h0,
                          1'b1, ST_EXCEEDS_NEED, 8'h00));
        add_row(dir_entry(ACT_SET, 8'h00, 32'h00000005, 32'h0,
                          1'b1, ST_ACCEPTED, 8'h00));
        // resource 0 short on available wins over resource 1 over need
        add_row(dir_entry(ACT_REQUEST, 8'h00, 32'h0000FF06, 32'h0,
                          1'b1, ST_EXCEEDS_AVAIL, 8'h00));
        // need checked before available on the same resource
        add_row(dir_entry(ACT_REQUEST, 8'h00, 32'h000000FF, 32'h0,
                          1'b1, ST_EXCEEDS_NEED, 8'h00));
        add_row(dir_entry(ACT_REQUEST, 8'h00, 32'h0, 32'h0, 1'b0, ST_GRANTED, 8'h00));
        add_row(dir_entry(ACT_SET, 8'h00, 32'h40404040, 32'h0,
                          1'b1, ST_ACCEPTED, 8'h00));
        add_row(dir_entry(ACT_REQUEST, 8'h5A, 32'h01010101, 32'h0,
                          1'b0, ST_GRANTED, 8'h00));

        idle_pct = 32;
        foreach (dir_rows[k])
            issue(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            idle_pct = (ph < 3) ? 32 : (ph < 6) ? 69 : 0;
            write_res_setting(phase_settings[ph]);
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                it = random_item();
                if (it.act != ACT_NONE)
                    counted++;
                issue(it, 1'b0, '0);
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("** bankers_request_safety_check_top: PASSED **");
        else
            $display("** bankers_request_safety_check_top: FAILED **");
        $finish;
    end

    initial
    begin
        #(12 * 500000);
        $display("** bankers_request_safety_check_top: FAILED **");
        $finish;
    end

endmodule

@@ bankers_request_safety_check_top.f @@
+incdir+hdl
hdl/brsc_pkg.sv
hdl/bankers_request_safety_check_top.sv
tb/tb_bankers_request_safety_check_top.sv
